// File: hw/rtl/slcfk_pkg.sv
// Package for the sync/length/checksum frame key decoder.
// Holds the frame constants and the types shared by the parser and the key decoder.
// Depends on nothing.
package slcfk_pkg;

    // Frame layout constants.
    localparam int unsigned HEAD_DEPTH = 6;
    localparam logic [7:0] SYNC_FIRST  = 8'hFF;
    localparam logic [7:0] SYNC_SECOND = 8'h55;
    localparam logic [7:0] CMD_TAG     = 8'h05;

    // The first payload bytes of the most recent frames.
    typedef logic [HEAD_DEPTH-1:0][7:0] t_head;

    // Frame status for the byte that is being taken.
    typedef struct packed {
        logic frame_ok;   // checksum byte with a matching sum
        logic frame_bad;  // checksum byte with a wrong sum
        logic in_frame;   // parser past sync after this byte
    } t_frame_evt;

endpackage

// File: hw/rtl/slcfk_ifs.sv
// Valid/ready channel interfaces of the frame key decoder.
// One interface carries received bytes, the other carries results.
// Depends on nothing.

// Received byte channel.
interface slcfk_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// Result channel, one result for each received byte.
interface slcfk_res_if;
    logic valid;
    logic ready;
    logic key_pressed;
    logic frame_accepted;
    logic checksum_error;
    logic in_frame;

    modport source (output valid, output key_pressed, output frame_accepted,
                    output checksum_error, output in_frame, input ready);
    modport sink (input valid, input key_pressed, input frame_accepted,
                  input checksum_error, input in_frame, output ready);
endinterface

// File: hw/rtl/slcfk_parser.sv
// Frame parser: sync hunt, length, payload count, running sum and payload head store.
// Reports the frame status of each taken byte as a t_frame_evt.
// Depends on slcfk_pkg.
module slcfk_parser
    import slcfk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    output t_frame_evt o_evt,
    output t_head      o_head
);

    localparam logic [1:0] PH_SYNC1 = 2'd0;
    localparam logic [1:0] PH_SYNC2 = 2'd1;
    localparam logic [1:0] PH_LEN   = 2'd2;
    localparam logic [1:0] PH_BODY  = 2'd3;
    localparam logic [7:0] HEAD_END = 8'(HEAD_DEPTH);

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_count, n_count;
    logic [7:0] r_len, n_len;
    logic [7:0] r_sum, n_sum;
    t_head      r_head, n_head;
    logic [7:0] limit;
    logic       ok, bad;

    assign limit = r_len - 8'd1;

    // Next state for the byte on the input.
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_len   = r_len;
        n_sum   = r_sum;
        n_head  = r_head;
        ok      = 1'b0;
        bad     = 1'b0;
        unique case (r_phase)
            PH_SYNC1: begin
                if (i_byte == SYNC_FIRST) begin
                    n_phase = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                if (i_byte == SYNC_FIRST) begin
                    n_phase = PH_SYNC2;
                end else if (i_byte == SYNC_SECOND) begin
                    n_phase = PH_LEN;
                end else begin
                    n_phase = PH_SYNC1;
                end
            end
            PH_LEN: begin
                n_phase = PH_BODY;
                n_count = 8'd0;
                n_len   = i_byte;
                n_sum   = i_byte;
            end
            PH_BODY: begin
                if (r_count < limit) begin
                    // Payload byte: keep the first HEAD_DEPTH, sum all of them.
                    if (r_count < HEAD_END) begin
                        n_head[r_count[2:0]] = i_byte;
                    end
                    n_sum   = r_sum + i_byte;
                    n_count = r_count + 8'd1;
                end else begin
                    // Checksum byte ends the frame.
                    n_phase = PH_SYNC1;
                    ok      = (r_sum == i_byte);
                    bad     = (r_sum != i_byte);
                end
            end
            default: begin
                n_phase = PH_SYNC1;
            end
        endcase
    end

    assign o_evt.frame_ok  = ok;
    assign o_evt.frame_bad = bad;
    assign o_evt.in_frame  = n_phase[1];
    assign o_head          = r_head;

    // Parser state advances on each taken byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_count <= 8'd0;
            r_len   <= 8'd0;
            r_sum   <= 8'd0;
            r_head  <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_len   <= n_len;
            r_sum   <= n_sum;
            r_head  <= n_head;
        end
    end

endmodule

// File: hw/rtl/slcfk_key_decoder.sv
// Key decoder: threshold register, ADC compare and the key flag.
// Uses the frame status and payload head from the parser.
// Depends on slcfk_pkg.
module slcfk_key_decoder
    import slcfk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_take,
    input  t_frame_evt  i_evt,
    input  t_head       i_head,
    output logic        o_key_next
);

    logic [15:0] r_thresh;
    logic        r_key, n_key;
    logic [15:0] left, right;
    logic        tagged_cmd;

    // Little-endian ADC values from the stored payload head.
    assign left       = {i_head[3], i_head[2]};
    assign right      = {i_head[5], i_head[4]};
    assign tagged_cmd = (i_head[0] == CMD_TAG) && (i_head[1] == CMD_TAG);

    // A good frame with the command tag decides the key flag.
    always_comb begin
        n_key = r_key;
        if (i_evt.frame_ok && tagged_cmd) begin
            n_key = (left < r_thresh) || (right < r_thresh);
        end
    end

    assign o_key_next = n_key;

    // Threshold register and key flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= 16'd0;
            r_key    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thresh <= i_cfg_data;
            end
            if (i_take) begin
                r_key <= n_key;
            end
        end
    end

endmodule

// File: hw/rtl/sync_length_checksum_frame_key_decoder.sv
// Top level of the sync/length/checksum frame key decoder.
// Instantiates slcfk_parser and slcfk_key_decoder; uses slcfk_pkg and slcfk_ifs.
//
//   Channel   Direction  Contents
//   i_rx      in         rx_byte, one received byte per request
//   o_res     out        key_pressed, frame_accepted, checksum_error, in_frame
//   i_cfg_*   in         press_threshold write, 16 bits
//
// One byte is taken per cycle while the output register can accept it; its result
// is registered there. The parser and key flag update in the cycle a byte is taken.
// A byte is taken whenever the output register is empty or being drained, so a
// stalled result stops new bytes only while it waits. Reset is synchronous and
// clears the parser state, payload head, key flag, threshold and valid flag.
module sync_length_checksum_frame_key_decoder
    import slcfk_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_data,
    slcfk_byte_if.sink   i_rx,
    slcfk_res_if.source  o_res
);

    logic       take;
    t_frame_evt evt;
    t_head      head;
    logic       key_next;
    logic       r_valid;
    logic       r_key, r_ok, r_bad, r_in_frame;

    // Take a request when the result register is free or being emptied.
    assign i_rx.ready = !r_valid || o_res.ready;
    assign take       = i_rx.valid && i_rx.ready;

    slcfk_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_rx.rx_byte),
        .o_evt   (evt),
        .o_head  (head)
    );

    slcfk_key_decoder u_key (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_take     (take),
        .i_evt      (evt),
        .i_head     (head),
        .o_key_next (key_next)
    );

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_key      <= key_next;
            r_ok       <= evt.frame_ok;
            r_bad      <= evt.frame_bad;
            r_in_frame <= evt.in_frame;
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.key_pressed    = r_key;
    assign o_res.frame_accepted = r_ok;
    assign o_res.checksum_error = r_bad;
    assign o_res.in_frame       = r_in_frame;

endmodule
